/* hw/rtl/fsync_pkg.sv */
// Shared types, constants and codes of the frame synchronizer.
package fsync_pkg;

  localparam int FRAME_LEN_DEF = 32;
  localparam int NBANK = 4;
  localparam int BANK_W = 2;
  localparam int IDX_W = 6;
  localparam int CFG_IDX_W = 2;

  localparam logic [7:0] SYNC_RST = 8'd71;
  localparam logic [3:0] GOOD_RST = 4'd3;
  localparam logic [3:0] BAD_RST = 4'd3;
  localparam logic [3:0] CNT_MAX = 4'd15;

  localparam logic [CFG_IDX_W-1:0] REG_SYNC = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GOOD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BAD = 2'd2;

  typedef enum logic [1:0] {
    ST_HUNT    = 2'd0,
    ST_CONFIRM = 2'd1,
    ST_LOCKED  = 2'd2,
    ST_LOSS    = 2'd3
  } sync_st_t;

  typedef struct packed {
    logic              en;
    logic [BANK_W-1:0] bank;
    logic [IDX_W-1:0]  idx;
    logic [7:0]        data;
  } mem_wr_t;

  typedef struct packed {
    logic [BANK_W-1:0] bank;
    sync_st_t          state;
  } frame_cmd_t;

  typedef struct packed {
    logic [7:0]       data;
    logic [IDX_W-1:0] idx;
    logic             last;
    sync_st_t         state;
  } result_t;

endpackage

/* hw/rtl/fsync_front.sv */
// Front end: configuration registers, sync state machine and frame store writes.
module fsync_front import fsync_pkg::*; #(
  parameter int FRAME_LEN = FRAME_LEN_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data,
  input  logic                 push,
  input  logic [7:0]           data_byte,
  output logic                 full,
  output mem_wr_t              wr,
  output logic                 cmd_push,
  output frame_cmd_t           cmd,
  input  logic                 frame_done
);

  localparam int POS_W = $clog2(FRAME_LEN + 1);
  localparam logic [POS_W-1:0] FL = POS_W'(FRAME_LEN);
  localparam int PEND_W = $clog2(NBANK);
  localparam logic [PEND_W-1:0] PEND_MAX = PEND_W'(NBANK - 1);

  logic [7:0]        sync_word;
  logic [3:0]        good_threshold;
  logic [3:0]        bad_threshold;
  sync_st_t          state, state_next;
  logic [POS_W-1:0]  pos, pos_next, pos_eff;
  logic [3:0]        good_cnt, good_next, good_inc, eff_good;
  logic [3:0]        bad_cnt, bad_next, bad_inc, eff_bad;
  logic [BANK_W-1:0] wbank;
  logic [PEND_W-1:0] pending;
  logic              accept, is_sync, boundary, store, emit;
  logic [POS_W-1:0]  store_pos;

  assign accept = push && !full;
  assign is_sync = (data_byte == sync_word);
  assign boundary = (pos >= FL);
  assign pos_eff = boundary ? '0 : pos;
  assign eff_good = (good_threshold == 4'd0) ? 4'd1 : good_threshold;
  assign eff_bad = (bad_threshold == 4'd0) ? 4'd1 : bad_threshold;
  assign good_inc = (good_cnt == CNT_MAX) ? good_cnt : good_cnt + 4'd1;
  assign bad_inc = (bad_cnt == CNT_MAX) ? bad_cnt : bad_cnt + 4'd1;
  assign full = (state == ST_LOCKED) && boundary && (pending == PEND_MAX);

  always_comb begin
    state_next = state;
    pos_next = pos;
    good_next = good_cnt;
    bad_next = bad_cnt;
    store = 1'b0;
    store_pos = pos_eff;
    emit = 1'b0;
    if (accept) begin
      case (state)
        ST_HUNT: begin
          if (is_sync) begin
            store = 1'b1;
            store_pos = '0;
            pos_next = POS_W'(1);
            good_next = 4'd0;
            state_next = ST_CONFIRM;
          end
        end
        ST_CONFIRM: begin
          if (boundary && !is_sync) begin
            state_next = ST_HUNT;
            pos_next = '0;
          end else begin
            if (boundary) begin
              good_next = good_inc;
              if (good_inc >= eff_good) begin
                state_next = ST_LOCKED;
              end
            end
            store = 1'b1;
            pos_next = pos_eff + POS_W'(1);
          end
        end
        ST_LOCKED: begin
          store = 1'b1;
          pos_next = pos_eff + POS_W'(1);
          if (boundary) begin
            emit = 1'b1;
            if (!is_sync) begin
              bad_next = 4'd1;
              if (eff_bad <= 4'd1) begin
                state_next = ST_HUNT;
                pos_next = '0;
                store = 1'b0;
              end else begin
                state_next = ST_LOSS;
              end
            end
          end
        end
        ST_LOSS: begin
          store = 1'b1;
          pos_next = pos_eff + POS_W'(1);
          if (boundary) begin
            if (is_sync) begin
              bad_next = 4'd0;
              state_next = ST_LOCKED;
            end else begin
              bad_next = bad_inc;
              if (bad_inc >= eff_bad) begin
                state_next = ST_HUNT;
                pos_next = '0;
                store = 1'b0;
              end
            end
          end
        end
        default: begin
          state_next = ST_HUNT;
        end
      endcase
    end
  end

  assign wr.en = store;
  assign wr.bank = emit ? wbank + BANK_W'(1) : wbank;
  assign wr.idx = IDX_W'(store_pos);
  assign wr.data = data_byte;
  assign cmd_push = emit;
  assign cmd.bank = wbank;
  assign cmd.state = state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_word <= SYNC_RST;
      good_threshold <= GOOD_RST;
      bad_threshold <= BAD_RST;
      state <= ST_HUNT;
      pos <= '0;
      good_cnt <= 4'd0;
      bad_cnt <= 4'd0;
      wbank <= '0;
      pending <= '0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_SYNC: sync_word <= cfg_data;
          REG_GOOD: good_threshold <= cfg_data[3:0];
          REG_BAD:  bad_threshold <= cfg_data[3:0];
          default: ;
        endcase
      end
      state <= state_next;
      pos <= pos_next;
      good_cnt <= good_next;
      bad_cnt <= bad_next;
      if (emit) begin
        wbank <= wbank + BANK_W'(1);
      end
      pending <= pending + PEND_W'(emit) - PEND_W'(frame_done);
    end
  end

endmodule

/* hw/rtl/fsync_cmd_fifo.sv */
// Short queue of frame emit commands between the front and back ends.
module fsync_cmd_fifo import fsync_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  frame_cmd_t din,
  input  logic       pop,
  output frame_cmd_t dout,
  output logic       empty
);

  localparam int PTR_W = $clog2(NBANK);
  localparam int CNT_W = $clog2(NBANK + 1);

  frame_cmd_t       entries [NBANK];
  logic [PTR_W-1:0] wptr, rptr;
  logic [CNT_W-1:0] count;

  assign empty = (count == '0);
  assign dout = entries[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + PTR_W'(1);
      end
      if (pop) begin
        rptr <= rptr + PTR_W'(1);
      end
      count <= count + CNT_W'(push) - CNT_W'(pop);
    end
  end

endmodule

/* hw/rtl/fsync_back.sv */
// Back end: banked frame store and the read-out of frames as result beats.
module fsync_back import fsync_pkg::*; #(
  parameter int FRAME_LEN = FRAME_LEN_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  mem_wr_t    wr,
  input  logic       cmd_empty,
  input  frame_cmd_t cmd,
  output logic       cmd_pop,
  output logic       frame_done,
  output result_t    res,
  output logic       empty,
  input  logic       pop
);

  localparam int AW = (FRAME_LEN > 1) ? $clog2(FRAME_LEN) : 1;
  localparam int DEPTH = NBANK << AW;
  localparam logic [IDX_W-1:0] LAST = IDX_W'(FRAME_LEN - 1);

  logic [7:0]        mem [DEPTH];
  logic [7:0]        rd_data;
  logic              active, rd_v, rd_en, last_rd, deq;
  logic [BANK_W-1:0] rbank;
  sync_st_t          rstate;
  logic [IDX_W-1:0]  ridx;
  result_t           rd_meta;
  result_t           ofifo [2];
  logic              wptr, rptr;
  logic [1:0]        ocnt, occ;

  assign deq = pop && (ocnt != 2'd0);
  assign occ = ocnt + 2'(rd_v);
  assign last_rd = (ridx == LAST);
  assign rd_en = active && ((occ < 2'd2) || deq);
  assign frame_done = rd_en && last_rd;
  assign cmd_pop = !active && !cmd_empty;
  assign res = ofifo[rptr];
  assign empty = (ocnt == 2'd0);

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[{wr.bank, wr.idx[AW-1:0]}] <= wr.data;
    end
    if (rd_en) begin
      rd_data <= mem[{rbank, ridx[AW-1:0]}];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      rbank <= cmd.bank;
      rstate <= cmd.state;
      ridx <= '0;
    end else if (rd_en) begin
      ridx <= ridx + IDX_W'(1);
    end
    if (rd_en) begin
      rd_meta.data <= '0;
      rd_meta.idx <= ridx;
      rd_meta.last <= last_rd;
      rd_meta.state <= rstate;
    end
    if (rd_v) begin
      ofifo[wptr] <= '{data: rd_data, idx: rd_meta.idx, last: rd_meta.last,
                       state: rd_meta.state};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      rd_v <= 1'b0;
      wptr <= 1'b0;
      rptr <= 1'b0;
      ocnt <= 2'd0;
    end else begin
      if (cmd_pop) begin
        active <= 1'b1;
      end else if (frame_done) begin
        active <= 1'b0;
      end
      rd_v <= rd_en;
      if (rd_v) begin
        wptr <= !wptr;
      end
      if (deq) begin
        rptr <= !rptr;
      end
      ocnt <= ocnt + 2'(rd_v) - 2'(deq);
    end
  end

endmodule

/* hw/rtl/frame_sync_hunt_confirm_lock_core.sv */
// Top level of the hunt, confirm, lock and loss-check frame synchronizer.
// Input: one byte per cycle while full is low; full rises only at a locked frame boundary
// while three frames still wait to be read out of the four-bank frame store.
// Output: after its boundary byte a frame's command is queued, and its FRAME_LEN beats are read
// out of the frame store through a two-entry output queue, one beat per cycle while pop is held.
// Reset is synchronous; it clears state, counters and queues; frame store contents are kept.
module frame_sync_hunt_confirm_lock_core import fsync_pkg::*; #(
  parameter int FRAME_LEN = FRAME_LEN_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data,
  input  logic                 push,
  output logic                 full,
  input  logic [7:0]           data_byte,
  output logic                 empty,
  input  logic                 pop,
  output logic [7:0]           frame_byte,
  output logic [5:0]           byte_index,
  output logic                 last_of_frame,
  output logic [1:0]           lock_state
);

  mem_wr_t    wr;
  logic       cmd_push, cmd_pop, cmd_empty, frame_done;
  frame_cmd_t cmd_in, cmd_out;
  result_t    res;

  fsync_front #(.FRAME_LEN(FRAME_LEN)) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .push       (push),
    .data_byte  (data_byte),
    .full       (full),
    .wr         (wr),
    .cmd_push   (cmd_push),
    .cmd        (cmd_in),
    .frame_done (frame_done)
  );

  fsync_cmd_fifo u_cmd_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (cmd_push),
    .din   (cmd_in),
    .pop   (cmd_pop),
    .dout  (cmd_out),
    .empty (cmd_empty)
  );

  fsync_back #(.FRAME_LEN(FRAME_LEN)) u_back (
    .clk        (clk),
    .rst        (rst),
    .wr         (wr),
    .cmd_empty  (cmd_empty),
    .cmd        (cmd_out),
    .cmd_pop    (cmd_pop),
    .frame_done (frame_done),
    .res        (res),
    .empty      (empty),
    .pop        (pop)
  );

  assign frame_byte = res.data;
  assign byte_index = res.idx;
  assign last_of_frame = res.last;
  assign lock_state = res.state;

endmodule

/* hw/rtl/fsync_checker.sv */
// Port-level checks of the frame synchronizer and their binding to the top level.
module fsync_checker import fsync_pkg::*; #(
  parameter int FRAME_LEN = FRAME_LEN_DEF
) (
  input logic       clk,
  input logic       rst,
  input logic       full,
  input logic       empty,
  input logic       pop,
  input logic [7:0] frame_byte,
  input logic [5:0] byte_index,
  input logic       last_of_frame,
  input logic [1:0] lock_state
);

  logic [5:0] exp_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      exp_idx <= 6'd0;
    end else if (pop && !empty) begin
      exp_idx <= last_of_frame ? 6'd0 : byte_index + 6'd1;
    end
  end

  a_reset_idle: assert property (@(posedge clk) rst |=> (empty && !full))
    else $error("Queues not idle after reset.");

  a_index_order: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (byte_index == exp_idx))
    else $error("Frame beat out of order.");

  a_last_index: assert property (@(posedge clk) disable iff (rst)
    (!empty && last_of_frame) |-> (byte_index == 6'(FRAME_LEN - 1)))
    else $error("Last beat at the wrong position.");

  a_state_in_frame: assert property (@(posedge clk) disable iff (rst)
    (!empty && pop && !last_of_frame) |=> (empty || lock_state == $past(lock_state)))
    else $error("Lock state changed within a frame.");

  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(frame_byte) && $stable(byte_index)))
    else $error("Stalled beat changed.");

endmodule

bind frame_sync_hunt_confirm_lock_core fsync_checker #(.FRAME_LEN(FRAME_LEN)) u_fsync_checker (
  .clk           (clk),
  .rst           (rst),
  .full          (full),
  .empty         (empty),
  .pop           (pop),
  .frame_byte    (frame_byte),
  .byte_index    (byte_index),
  .last_of_frame (last_of_frame),
  .lock_state    (lock_state)
);
